// File: design/cbd_pkg.sv
// Shared codes and defaults for the circular buffer deque.
package cbd_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 5;
  localparam int unsigned CFG_W  = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

// File: design/cbd_ring_mem.sv
// Ring store: one write port, one read port, registered read data.
module cbd_ring_mem
  import cbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/cbd_ctrl.sv
// Pointer and count control: decodes a request, drives the ring store, registers status.
module cbd_ctrl
  import cbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     req_go,
  input  logic [REQ_W-1:0]         req_type,
  output logic                     mem_wr_en,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output logic                     res_valid,
  output logic                     res_rd_sel,
  output logic [STAT_W-1:0]        res_status,
  output logic [FILL_W-1:0]        res_fill
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  function automatic logic [SUM_W-1:0] wrap(input logic [SUM_W-1:0] v,
                                            input logic [SUM_W-1:0] c);
    return (v >= c) ? v - c : v;
  endfunction

  logic [CFG_W-1:0]  cap_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              valid_r;
  logic              rd_sel_r, rd_sel_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [FILL_W-1:0] fill_r;

  logic [CMP_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  cap;
  logic [SUM_W-1:0]  cap_s;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  front_s;
  logic [SUM_W-1:0]  cnt_s;
  logic [SUM_W-1:0]  back_free;
  logic [SUM_W-1:0]  back_last;
  logic [SUM_W-1:0]  front_inc;
  logic [IDX_W-1:0]  front_dec;

  // effective capacity: zero acts as one, clipped to the store depth
  always_comb begin
    cfg_ext = CMP_W'(cap_r);
    if (cfg_ext < ONE_C) begin
      cap = CNT_W'(ONE_C);
    end else if (cfg_ext > DEPTH_C) begin
      cap = CNT_W'(DEPTH_C);
    end else begin
      cap = CNT_W'(cfg_ext);
    end
  end

  assign cap_s   = SUM_W'(cap);
  assign front   = (SUM_W'(front_r) >= cap_s) ? '0 : front_r;
  assign cnt     = (cnt_r > cap) ? cap : cnt_r;
  assign front_s = SUM_W'(front);
  assign cnt_s   = SUM_W'(cnt);

  assign back_free = wrap(front_s + cnt_s, cap_s);
  assign back_last = wrap(front_s + cnt_s - SUM_W'(1), cap_s);
  assign front_inc = wrap(front_s + SUM_W'(1), cap_s);
  assign front_dec = (front == '0) ? IDX_W'(cap_s - SUM_W'(1)) : front - IDX_W'(1);

  always_comb begin
    front_nxt  = front;
    cnt_nxt    = cnt;
    status_nxt = STAT_OK;
    rd_sel_nxt = 1'b0;
    mem_wr_en  = 1'b0;
    mem_rd_en  = 1'b0;
    mem_addr   = front;
    unique case (req_type) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (cnt >= cap) begin
          status_nxt = STAT_FULL;
        end else begin
          mem_wr_en = req_go;
          cnt_nxt   = cnt + CNT_W'(1);
          if (req_type == REQ_PUSH_FRONT) begin
            front_nxt = front_dec;
            mem_addr  = front_dec;
          end else begin
            mem_addr = IDX_W'(back_free);
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (cnt == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          mem_rd_en  = req_go;
          rd_sel_nxt = 1'b1;
          if (req_type == REQ_POP_BACK || req_type == REQ_PEEK_BACK) begin
            mem_addr = IDX_W'(back_last);
          end
          if (req_type == REQ_POP_FRONT) begin
            front_nxt = IDX_W'(front_inc);
          end
          if (req_type == REQ_POP_FRONT || req_type == REQ_POP_BACK) begin
            cnt_nxt = cnt - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= req_go;
      if (cfg_we) begin
        cap_r   <= cfg_wdata;
        front_r <= '0;
        cnt_r   <= '0;
      end else if (req_go) begin
        front_r <= front_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      rd_sel_r <= rd_sel_nxt;
      status_r <= status_nxt;
      fill_r   <= FILL_W'(cnt_nxt);
    end
  end

  assign res_valid  = valid_r;
  assign res_rd_sel = rd_sel_r;
  assign res_status = status_r;
  assign res_fill   = fill_r;

endmodule

// File: design/circular_buffer_deque_top.sv
// Circular buffer deque top: command port, ring store and pointer control.
// Results are registered: out_valid for a request rises in the cycle after the edge that accepts it.
// Throughput: one request per cycle; busy stays low, pointers update at the accept edge
//   and the ring store's single read port is the only path to read data.
// Reset: synchronous active-low rst_n empties the queue and sets capacity to 16;
//   store contents are not cleared. The receiver cannot stall results.
module circular_buffer_deque_top
  import cbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request port
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [DATA_W-1:0] in_push_value,
  // result port, one-cycle strobe
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [FILL_W-1:0]        out_fill_count,
  // capacity register
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                     req_go;
  logic                     mem_wr_en;
  logic                     mem_rd_en;
  logic [IDX_W-1:0]         mem_addr;
  logic signed [DATA_W-1:0] mem_rd_data;
  logic                     res_rd_sel;

  // every request completes in one pass, so the port never pushes back
  assign busy   = 1'b0;
  assign req_go = start & ~busy;

  cbd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_go     (req_go),
    .req_type   (in_req_type),
    .mem_wr_en  (mem_wr_en),
    .mem_rd_en  (mem_rd_en),
    .mem_addr   (mem_addr),
    .res_valid  (out_valid),
    .res_rd_sel (res_rd_sel),
    .res_status (out_status),
    .res_fill   (out_fill_count)
  );

  // a write lands in the store at its accept edge, before any later read samples it, so
  // back-to-back push then peek needs no forwarding
  cbd_ring_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_addr),
    .wr_data (in_push_value),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_addr),
    .rd_data (mem_rd_data)
  );

  // pushes, refusals and unused codes return a zero word
  assign out_read_value = res_rd_sel ? mem_rd_data : '0;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular buffer deque: directed table, then random requests.
module tb_top;
  import cbd_pkg::*;

  localparam int WDOG_LIMIT = 2000;   // quiet cycles before the run is called hung
  localparam int MAX_SHOWN  = 10;     // mismatches printed in full
  localparam int IDLE_PCT   = 37;     // sender idles in about this share of cycles
  localparam int IDX_W      = $clog2(DEPTH_DEF);
  localparam int NUM_DIR    = 26;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_LEN  = 40;

  // request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  // one result word, in port order
  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [STAT_W-1:0] st;
    logic [FILL_W-1:0] fill;
  } deq_word_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // directed row: a request or a capacity write; pinned rows carry a typed-in result
  typedef struct packed {
    row_kind_t         kind;
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] val;
    logic              pinned;
    deq_word_t         word;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // fresh after reset, capacity 16: both ends empty
    '{ROW_REQ, REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_EMPTY, 5'd0}},
    '{ROW_REQ, REQ_PEEK_BACK,  32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_EMPTY, 5'd0}},
    // extreme values at each end
    '{ROW_REQ, REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, STAT_OK,    5'd1}},
    '{ROW_REQ, REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0000_0000, STAT_OK,    5'd2}},
    '{ROW_REQ, REQ_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h8000_0000, STAT_OK,    5'd2}},
    '{ROW_REQ, REQ_PEEK_BACK,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STAT_OK,    5'd2}},
    // unused codes leave everything alone
    '{ROW_REQ, REQ_SPARE_6,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STAT_OK,    5'd2}},
    '{ROW_REQ, REQ_SPARE_7,    32'h5555_5555, 1'b1, '{32'h0000_0000, STAT_OK,    5'd2}},
    '{ROW_REQ, REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STAT_OK,    5'd1}},
    '{ROW_REQ, REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, STAT_OK,    5'd0}},
    '{ROW_REQ, REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_EMPTY, 5'd0}},
    // capacity 0 behaves as a single slot
    '{ROW_CFG, REQ_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
    '{ROW_REQ, REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STAT_OK,    5'd1}},
    '{ROW_REQ, REQ_PUSH_BACK,  32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, STAT_FULL,  5'd1}},
    '{ROW_REQ, REQ_PEEK_BACK,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, STAT_OK,    5'd1}},
    '{ROW_REQ, REQ_POP_FRONT,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, STAT_OK,    5'd0}},
    // two slots: front pointer wraps below zero
    '{ROW_CFG, REQ_PUSH_FRONT, 32'h0000_0002, 1'b0, '0},
    '{ROW_REQ, REQ_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
    '{ROW_REQ, REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0},
    '{ROW_REQ, REQ_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_FULL,  5'd2}},
    '{ROW_REQ, REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{ROW_REQ, REQ_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
    // capacity above depth clamps; a write empties a non-empty queue
    '{ROW_CFG, REQ_PUSH_FRONT, 32'h0000_001F, 1'b0, '0},
    '{ROW_REQ, REQ_PUSH_BACK,  32'h0000_0005, 1'b0, '0},
    '{ROW_CFG, REQ_PUSH_FRONT, 32'h0000_0011, 1'b0, '0},
    '{ROW_REQ, REQ_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_EMPTY, 5'd0}}
  };

  // DUT ports
  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         in_req_type;
  logic signed [DATA_W-1:0] in_push_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STAT_W-1:0]        out_status;
  logic [FILL_W-1:0]        out_fill_count;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;

  // shadow deque state
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  logic [IDX_W-1:0]  head_idx;
  logic [FILL_W-1:0] held_cnt;
  logic [CFG_W-1:0]  cap_reg;

  deq_word_t pending_words [$];   // expected words, oldest first
  logic      pin_en;              // current word has a typed-in result
  deq_word_t pin_word;
  logic      idle_en;
  int        mismatches;
  int        quiet_cycles;

  circular_buffer_deque_top #(.DEPTH(DEPTH_DEF)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_fill_count(out_fill_count),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register value to ring size: 0 acts as 1, anything past the depth acts as the depth
  function automatic logic [FILL_W-1:0] ring_size(input logic [CFG_W-1:0] r);
    if (r == '0) return FILL_W'(1);
    if (r > DEPTH_DEF) return FILL_W'(DEPTH_DEF);
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] ring_wrap(input logic [FILL_W:0] v,
                                                  input logic [FILL_W-1:0] sz);
    return (v >= sz) ? FILL_W'(v - sz) : FILL_W'(v);
  endfunction

  // Advance the shadow deque by one request and return the word it should produce.
  function automatic deq_word_t deque_predict(input logic [REQ_W-1:0] req,
                                              input logic [DATA_W-1:0] val);
    deq_word_t        w;
    logic [FILL_W-1:0] sz;
    logic [FILL_W-1:0] hd;
    logic [FILL_W-1:0] slot;
    w  = '{'0, STAT_OK, '0};
    sz = ring_size(cap_reg);
    hd = FILL_W'(head_idx);
    if (hd >= sz) hd = '0;
    if (held_cnt > sz) held_cnt = sz;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held_cnt >= sz) begin
          w.st = STAT_FULL;
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            hd   = (hd == '0) ? sz - 1'b1 : hd - 1'b1;
            slot = hd;
          end else begin
            slot = ring_wrap(hd + held_cnt, sz);
          end
          ring_mem[slot[IDX_W-1:0]] = val;
          held_cnt++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (held_cnt == '0) begin
          w.st = STAT_EMPTY;
        end else begin
          if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) slot = hd;
          else slot = ring_wrap(hd + held_cnt - 1'b1, sz);
          w.rd = ring_mem[slot[IDX_W-1:0]];
          if (req == REQ_POP_FRONT) begin
            hd = ring_wrap(hd + 1'b1, sz);
            held_cnt--;
          end else if (req == REQ_POP_BACK) begin
            held_cnt--;
          end
        end
      end
      default: ;  // spare codes: no change
    endcase
    head_idx = hd[IDX_W-1:0];
    w.fill   = held_cnt;
    return w;
  endfunction

  // Monitor: check the strobed word against the oldest expectation, then log any
  // word accepted at this edge. A word taken at an edge strobes during the next
  // cycle, so it is checked at the edge ending that cycle, after its expectation is queued.
  always @(posedge clk) begin
    deq_word_t got;
    deq_word_t want;
    deq_word_t pred;
    if (!rst_n) begin
      cap_reg  = CAP_RESET;
      head_idx = '0;
      held_cnt = '0;
    end else begin
      if (out_valid) begin
        got = '{out_read_value, out_status, out_fill_count};
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: unexpected word rd=%h st=%0d fill=%0d",
                     $realtime, got.rd, got.st, got.fill);
        end else begin
          want = pending_words.pop_front();
          if (got.rd !== want.rd || got.st !== want.st || got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: mismatch want rd=%h st=%0d fill=%0d, got rd=%h st=%0d fill=%0d",
                       $realtime, want.rd, want.st, want.fill, got.rd, got.st, got.fill);
          end
        end
      end
      if (start && !busy) begin
        pred = deque_predict(in_req_type, in_push_value);
        pending_words.push_back(pin_en ? pin_word : pred);
      end
      // capacity write empties the queue
      if (cfg_we) begin
        cap_reg  = cfg_wdata;
        head_idx = '0;
        held_cnt = '0;
      end
    end
  end

  // Watchdog: any handshake or write resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("[circular_buffer_deque_top] ERROR");
        $finish;
      end
    end
  end

  // Present one word at a falling edge, with random idle cycles first, and hold
  // it until the rising edge that takes it.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                           input logic pin, input deq_word_t pw);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      start         = 1'b0;
      in_req_type   = REQ_W'($urandom);   // noise while idle must be ignored
      in_push_value = $urandom;
      @(negedge clk);
    end
    start         = 1'b1;
    in_req_type   = req;
    in_push_value = val;
    pin_en        = pin;
    pin_word      = pw;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Capacity writes happen only with nothing in flight.
  task automatic write_capacity(input logic [CFG_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random phase: push share sets whether the queue tends to fill or drain.
  task automatic run_phase(input logic [CFG_W-1:0] cap, input int push_pct);
    int               roll;
    logic [REQ_W-1:0] req;
    logic [DATA_W-1:0] val;
    write_capacity(cap);
    repeat (PHASE_LEN) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        req = roll[0] ? REQ_SPARE_7 : REQ_SPARE_6;
      end else if (roll < 4 + push_pct) begin
        req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        case ($urandom_range(0, 3))
          0:       req = REQ_POP_FRONT;
          1:       req = REQ_POP_BACK;
          2:       req = REQ_PEEK_FRONT;
          default: req = REQ_PEEK_BACK;
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else begin
        val = $urandom;
      end
      send_word(req, val, 1'b0, '0);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cap [NUM_PHASES];
    int               phase_push [NUM_PHASES];
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = '0;
    in_push_value = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    pin_en        = 1'b0;
    pin_word      = '0;
    idle_en       = 1'b1;
    mismatches    = 0;
    quiet_cycles  = 0;

    // capacities cover the clamp cases at both ends plus random picks
    phase_cap  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, CFG_W'($urandom_range(0, 31)),
                   5'd17, CFG_W'($urandom_range(0, 31)), 5'd2, 5'd16};
    phase_push = '{75, 50, 45, 75, 50, $urandom_range(30, 70), 40,
                   $urandom_range(30, 70), 50, 60};

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG)
        write_capacity(DIR_TAB[i].val[CFG_W-1:0]);
      else
        send_word(DIR_TAB[i].req, DIR_TAB[i].val, DIR_TAB[i].pinned, DIR_TAB[i].word);
    end

    // random phases; two back-to-back phases run with the sender never idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_en = !(p == 3 || p == 4);
      run_phase(phase_cap[p], phase_push[p]);
    end

    // drain, then let the pipeline settle
    @(negedge clk);
    start = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("[circular_buffer_deque_top] OK");
    end else begin
      $display("[circular_buffer_deque_top] ERROR");
    end
    $finish;
  end

endmodule
